// ===== hdl/fte_pkg.sv =====
// Package: shared types, codes and constants of the table entry engine.
`default_nettype none
package fte_pkg;

	localparam int TABLE_BYTES_DEFAULT = 8192;

	// byte offset width: covers 2 * 65535 plus headroom for the bound compare
	localparam int OFF_W      = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FAT_KIND  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_FREE = 2'd1;

	localparam logic [1:0] KIND_FAT12 = 2'd0;
	localparam logic [1:0] KIND_FAT16 = 2'd1;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam logic [15:0] COUNT_UNKNOWN = 16'hFFFF;
	localparam logic [15:0] COUNT_MAX     = 16'hFFFE;
	localparam logic [15:0] END_MARK      = 16'hFFFF;
	localparam logic [15:0] BAD_MARK      = 16'hFFF7;
	localparam logic [15:0] NEXT_ERR      = 16'hFFFF;

	localparam logic [7:0] LO_NIBBLE = 8'h0F;
	localparam logic [7:0] HI_NIBBLE = 8'hF0;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MODIFY
	} fte_state_t;

	typedef struct packed {
		logic clear;
		logic accept;
		logic read;
		logic commit;
	} fte_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_free;
	} fte_stat_t;

endpackage
`default_nettype wire

// ===== hdl/fte_req_if.sv =====
// Interface: request channel (action, cluster, link value).
`default_nettype none
interface fte_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] cluster;
	logic [15:0] link_value;

	modport source (output valid, action, cluster, link_value, input ready);
	modport sink (input valid, action, cluster, link_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/fte_rsp_if.sv =====
// Interface: response channel (status, next value, free count).
`default_nettype none
interface fte_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [15:0] next_value;
	logic [15:0] free_count;

	modport source (output valid, status, next_value, free_count, input ready);
	modport sink (input valid, status, next_value, free_count, output ready);
endinterface
`default_nettype wire

// ===== hdl/fte_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/fte_ctrl.sv =====
// Controller: clearing pass, request acceptance and read/modify sequencing.
`default_nettype none
module fte_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire fte_pkg::fte_stat_t stat,
	output logic                   req_ready,
	output fte_pkg::fte_cmd_t      cmd
);

	fte_pkg::fte_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fte_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			fte_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = fte_pkg::ST_IDLE;
				end
			end
			fte_pkg::ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_d = fte_pkg::ST_READ;
				end
			end
			fte_pkg::ST_READ: begin
				cmd.read = 1'b1;
				state_d  = fte_pkg::ST_MODIFY;
			end
			fte_pkg::ST_MODIFY: begin
				// hold the read until the output register can take the word
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = fte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fte_pkg::ST_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/fte_datapath.sv =====
// Datapath: table banks, entry pack/unpack, free count, config and output register.
`default_nettype none
module fte_datapath #(
	parameter int TABLE_BYTES = fte_pkg::TABLE_BYTES_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fte_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           req_action,
	input  wire logic [15:0]                    req_cluster,
	input  wire logic [15:0]                    req_link_value,
	input  wire fte_pkg::fte_cmd_t              cmd,
	output fte_pkg::fte_stat_t                  stat,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output logic                                rsp_status,
	output logic [15:0]                         rsp_next_value,
	output logic [15:0]                         rsp_free_count
);

	// even bytes in bank 0, odd bytes in bank 1: an entry's two bytes never share a bank
	localparam int ROWS   = (TABLE_BYTES + 1) / 2;
	localparam int ROW_AW = $clog2(ROWS);
	localparam logic [fte_pkg::OFF_W-1:0] OFF_LIMIT = fte_pkg::OFF_W'(TABLE_BYTES - 1);

	logic [1:0]  kind_q;
	logic [15:0] free_q, free_d;
	logic        action_q;
	logic [15:0] cluster_q;
	logic [15:0] link_q;
	logic        err_q;
	logic [ROW_AW-1:0] clr_row_q;

	logic                     fat12;
	logic [fte_pkg::OFF_W-1:0] off;
	logic                     odd_off;
	logic                     err;
	logic [ROW_AW-1:0]        row_a, row_b;
	logic [ROW_AW-1:0]        addr0, addr1;
	logic [7:0]               d0, d1, b0, b1, nb0, nb1;
	logic                     we0, we1, do_write;
	logic [ROW_AW-1:0]        waddr0, waddr1;
	logic [7:0]               wdata0, wdata1;
	logic [11:0]              e12;
	logic [15:0]              rd_value, next_d;

	// the initial free count register only matters through the count it loads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= fte_pkg::KIND_FAT12;
			free_q <= fte_pkg::COUNT_UNKNOWN;
		end else begin
			if (cfg_we && cfg_index == fte_pkg::REG_FAT_KIND) begin
				kind_q <= cfg_data[1:0];
			end
			if (cfg_we && cfg_index == fte_pkg::REG_INIT_FREE) begin
				free_q <= cfg_data;
			end else if (cmd.commit) begin
				free_q <= free_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
		end else if (cmd.clear) begin
			clr_row_q <= clr_row_q + ROW_AW'(1);
		end
	end

	assign stat.clear_last = (clr_row_q == ROW_AW'(ROWS - 1));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			action_q  <= req_action;
			cluster_q <= req_cluster;
			link_q    <= req_link_value;
		end
		if (cmd.read) begin
			err_q <= err;
		end
	end

	// offset: 3n/2 for FAT12, 2n otherwise
	assign fat12   = (kind_q == fte_pkg::KIND_FAT12);
	assign off     = fat12 ? ({2'b00, cluster_q} + {3'b000, cluster_q[15:1]})
	                       : {1'b0, cluster_q, 1'b0};
	assign odd_off = off[0];
	assign err     = (kind_q != fte_pkg::KIND_FAT12 && kind_q != fte_pkg::KIND_FAT16)
	                 || (off >= OFF_LIMIT);

	assign row_a = off[ROW_AW:1];
	assign row_b = row_a + ROW_AW'(1);
	assign addr0 = odd_off ? row_b : row_a;
	assign addr1 = row_a;

	assign b0 = odd_off ? d1 : d0;
	assign b1 = odd_off ? d0 : d1;

	always_comb begin
		if (!fat12) begin
			nb0 = link_q[7:0];
			nb1 = link_q[15:8];
		end else if (cluster_q[0]) begin
			nb0 = {link_q[3:0], 4'h0} | (b0 & fte_pkg::LO_NIBBLE);
			nb1 = link_q[11:4];
		end else begin
			nb0 = link_q[7:0];
			nb1 = (b1 & fte_pkg::HI_NIBBLE) | {4'h0, link_q[11:8]};
		end
	end

	assign do_write = cmd.commit && (action_q == fte_pkg::ACT_WRITE) && !err_q;
	assign we0      = cmd.clear || do_write;
	assign we1      = cmd.clear || do_write;
	assign waddr0   = cmd.clear ? clr_row_q : addr0;
	assign waddr1   = cmd.clear ? clr_row_q : addr1;
	assign wdata0   = cmd.clear ? 8'h00 : (odd_off ? nb1 : nb0);
	assign wdata1   = cmd.clear ? 8'h00 : (odd_off ? nb0 : nb1);

	fte_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr0),
		.wdata (wdata0),
		.raddr (addr0),
		.rdata (d0)
	);

	fte_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr1),
		.wdata (wdata1),
		.raddr (addr1),
		.rdata (d1)
	);

	always_comb begin
		e12 = cluster_q[0] ? {b1, b0[7:4]} : {b1[3:0], b0};
		if (!fat12) begin
			rd_value = {b1, b0};
		end else if (e12[11:3] == 9'h1FF) begin
			rd_value = fte_pkg::END_MARK;
		end else if (e12 == fte_pkg::BAD_MARK[11:0]) begin
			rd_value = fte_pkg::BAD_MARK;
		end else begin
			rd_value = {4'h0, e12};
		end
	end

	always_comb begin
		if (err_q) begin
			next_d = fte_pkg::NEXT_ERR;
		end else if (action_q == fte_pkg::ACT_WRITE) begin
			next_d = 16'h0000;
		end else begin
			next_d = rd_value;
		end
	end

	// unknown count never moves; increments stop below the unknown mark
	always_comb begin
		free_d = free_q;
		if (do_write && free_q != fte_pkg::COUNT_UNKNOWN) begin
			if (link_q == 16'h0000) begin
				if (free_q < fte_pkg::COUNT_MAX) begin
					free_d = free_q + 16'd1;
				end
			end else if (free_q != 16'h0000) begin
				free_d = free_q - 16'd1;
			end
		end
	end

	assign stat.out_free = !rsp_valid || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_status     <= err_q ? fte_pkg::STATUS_BAD : fte_pkg::STATUS_OK;
			rsp_next_value <= next_d;
			rsp_free_count <= free_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/fat_table_entry_engine.sv =====
// Sequencing: accept registers the request, the entry is read from the byte banks,
//   then it is modified and, for a write, written back, and the result word is
//   registered at the output. One request at a time: the two byte banks each have
//   one read and one write port, and the entry is read before it is rewritten. A
//   stalled response holds the modify step. Reset: asynchronous; a clearing pass
//   zeroes the table row by row, with request.ready low; config writes are taken.
`default_nettype none
module fat_table_entry_engine #(
	parameter int TABLE_BYTES = fte_pkg::TABLE_BYTES_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [fte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [fte_pkg::CFG_DATA_W-1:0] cfg_data,
	fte_req_if.sink                             request,
	fte_rsp_if.source                           response
);

	fte_pkg::fte_cmd_t  cmd;
	fte_pkg::fte_stat_t stat;

	fte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.stat      (stat),
		.req_ready (request.ready),
		.cmd       (cmd)
	);

	fte_datapath #(.TABLE_BYTES(TABLE_BYTES)) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.req_action     (request.action),
		.req_cluster    (request.cluster),
		.req_link_value (request.link_value),
		.cmd            (cmd),
		.stat           (stat),
		.rsp_valid      (response.valid),
		.rsp_ready      (response.ready),
		.rsp_status     (response.status),
		.rsp_next_value (response.next_value),
		.rsp_free_count (response.free_count)
	);

endmodule
`default_nettype wire

// ===== hdl/fte_checker.sv =====
// Checker: port-level properties of the table entry engine, bound to the top level.
`default_nettype none
module fte_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic        rsp_status,
	input wire logic [15:0] rsp_next_value
);

	// a word waiting at the output stays until it is taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped before it was taken");

	// error words always carry the all-ones value
	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status |-> rsp_next_value == 16'hFFFF)
		else $error("error response without all-ones next value");

	// one request in flight: no new accept during read and modify
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready ##1 !req_ready)
		else $error("request accepted while another is in flight");

	// a fresh response word must be preceded by the accept of its request
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
		else $error("response word without a matching request");

endmodule

bind fat_table_entry_engine fte_checker u_fte_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (request.valid),
	.req_ready      (request.ready),
	.rsp_valid      (response.valid),
	.rsp_ready      (response.ready),
	.rsp_status     (response.status),
	.rsp_next_value (response.next_value)
);
`default_nettype wire
